// ----- design/rth_pkg.sv -----
// Shared types and constants for the RGB to HSL converter.
package rth_pkg;

  // Numerator, divisor and quotient widths of the rounding dividers.
  localparam int unsigned NUM_W         = 25;
  localparam int unsigned DEN_W         = 9;
  localparam int unsigned QUO_W         = 16;
  localparam int unsigned BITS_PER_STEP = 4;
  localparam int unsigned DIV_STAGES    = QUO_W / BITS_PER_STEP;

  // Hue numerator before rounding: at most 5760 * 255.
  localparam int unsigned VAL_W = 21;

  localparam logic [12:0] HUE_SECTOR = 13'd960;
  localparam logic [12:0] HUE_FULL   = 13'd5760;
  localparam logic [15:0] Q15_ONE    = 16'd32768;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic [12:0] hue_out;
    logic [15:0] saturation_out;
    logic [15:0] lightness_out;
  } hsl_t;

  // One division in flight: partial remainder, numerator bits still to be
  // consumed with quotient bits shifted in behind them, and the divisor.
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] sh;
    logic [DEN_W-1:0] den;
  } div_op_t;

  typedef struct packed {
    div_op_t     hue;
    div_op_t     sat;
    logic [15:0] lit_est;
    logic [8:0]  sum;
  } prep_out_t;

endpackage

// ----- design/rth_prep.sv -----
// Front stages: pixel capture, extremes and hue numerator, divider operands.
module rth_prep (
  input  logic               clk,
  input  logic [2:0]         en,
  input  rth_pkg::pixel_t    pix_in,
  output rth_pkg::prep_out_t prep_out
);

  localparam int unsigned VAL_W = rth_pkg::VAL_W;

  rth_pkg::pixel_t pix_r;

  logic [7:0] r, g, b;
  logic [7:0] mx, mn, d, x, y;
  logic [8:0] sum;
  logic [rth_pkg::VAL_W-1:0] base, slope, val;

  logic [7:0] d_r;
  logic [8:0] sum_r;
  logic [rth_pkg::VAL_W-1:0] val_r;

  logic [rth_pkg::NUM_W-1:0] hue_num, sat_num;
  logic [rth_pkg::DEN_W-1:0] hue_den, sat_den;
  logic [7:0]  den8;
  logic [22:0] lit_y;
  logic [30:0] lit_prod;

  rth_pkg::prep_out_t prep_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pix_r <= pix_in;
    end
  end

  assign r = pix_r.red_in;
  assign g = pix_r.green_in;
  assign b = pix_r.blue_in;

  // Extremes, then the hue numerator from the sector of the largest channel.
  always_comb begin
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d   = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    if (mx == r) begin
      x    = g;
      y    = b;
      base = (g >= b) ? '0 : VAL_W'(d) * VAL_W'(rth_pkg::HUE_FULL);
    end else if (mx == g) begin
      x    = b;
      y    = r;
      base = VAL_W'(d) * VAL_W'({rth_pkg::HUE_SECTOR, 1'b0});
    end else begin
      x    = r;
      y    = g;
      base = VAL_W'(d) * VAL_W'({rth_pkg::HUE_SECTOR, 2'b00});
    end
    if (x >= y) begin
      slope = VAL_W'(x - y) * VAL_W'(rth_pkg::HUE_SECTOR);
      val   = base + slope;
    end else begin
      slope = VAL_W'(y - x) * VAL_W'(rth_pkg::HUE_SECTOR);
      val   = base - slope;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      d_r   <= d;
      sum_r <= sum;
      val_r <= val;
    end
  end

  // Round-to-nearest divisions are posed as floor((2n + d) / 2d). A gray
  // pixel has a zero numerator, so its divisor is forced to one.
  always_comb begin
    hue_num = rth_pkg::NUM_W'({val_r, 1'b0}) + rth_pkg::NUM_W'(d_r);
    hue_den = (d_r == 8'd0) ? rth_pkg::DEN_W'(1) : {d_r, 1'b0};
    den8    = (sum_r >= 9'd255) ? 8'(9'd510 - sum_r) : sum_r[7:0];
    sat_num = rth_pkg::NUM_W'({d_r, 16'b0}) + rth_pkg::NUM_W'(den8);
    sat_den = (den8 == 8'd0) ? rth_pkg::DEN_W'(1) : {den8, 1'b0};
    // Lightness is floor(y / 255); y * 257 / 65536 is low by at most one.
    lit_y    = {sum_r, 14'b0} + 23'd127;
    lit_prod = {lit_y, 8'b0} + 31'(lit_y);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      prep_r.hue.rem <= hue_num[rth_pkg::NUM_W-1:rth_pkg::QUO_W];
      prep_r.hue.sh  <= hue_num[rth_pkg::QUO_W-1:0];
      prep_r.hue.den <= hue_den;
      prep_r.sat.rem <= sat_num[rth_pkg::NUM_W-1:rth_pkg::QUO_W];
      prep_r.sat.sh  <= sat_num[rth_pkg::QUO_W-1:0];
      prep_r.sat.den <= sat_den;
      prep_r.lit_est <= 16'(lit_prod[30:16]);
      prep_r.sum     <= sum_r;
    end
  end

  assign prep_out = prep_r;

endmodule

// ----- design/rth_div_step.sv -----
// One registered stage of a restoring divider, four quotient bits per stage.
module rth_div_step (
  input  logic             clk,
  input  logic             en,
  input  rth_pkg::div_op_t op_in,
  output rth_pkg::div_op_t op_out
);

  logic [rth_pkg::DEN_W:0]   t;
  logic                      ge;
  logic [rth_pkg::DEN_W-1:0] rem;
  logic [rth_pkg::QUO_W-1:0] sh;
  rth_pkg::div_op_t          op_r;

  always_comb begin
    rem = op_in.rem;
    sh  = op_in.sh;
    t   = '0;
    ge  = 1'b0;
    for (int i = 0; i < rth_pkg::BITS_PER_STEP; i++) begin
      t  = {rem, sh[rth_pkg::QUO_W-1]};
      ge = (t >= {1'b0, op_in.den});
      if (ge) t = t - {1'b0, op_in.den};
      rem = t[rth_pkg::DEN_W-1:0];
      sh  = {sh[rth_pkg::QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r.rem <= rem;
      op_r.sh  <= sh;
      op_r.den <= op_in.den;
    end
  end

  assign op_out = op_r;

endmodule

// ----- design/rgb_to_hsl.sv -----
// Top level of the pipelined RGB to HSL pixel converter.
//
// Usage: an 8-bit RGB pixel enters on in_data with in_valid; a transfer takes
// place at each rising edge where in_valid is high and in_stall is low. The
// HSL result leaves on out_data with out_valid, and is transferred when
// out_stall is low. Hue is in sixteenths of a degree (0..5759, zero for a
// gray pixel); saturation and lightness are Q1.15 values from 0 to 1.0.
// Throughput is one pixel per cycle while out_stall stays low: three front
// stages prepare the operands, then four stages of a shared-form restoring
// divider retire four quotient bits each for hue and saturation side by side,
// and a final output register holds the result.
// Every stage has its own valid bit, so a stage moves whenever the stage
// after it is empty or moving; a stalled receiver fills the bubbles first and
// in_stall rises only once every stage is full. Nothing is lost or repeated.
// Reset clears all valid bits; the data registers are not reset.
module rgb_to_hsl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  rth_pkg::pixel_t in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output rth_pkg::hsl_t   out_data
);

  localparam int unsigned PREP_STAGES = 3;
  localparam int unsigned PIPE        = PREP_STAGES + rth_pkg::DIV_STAGES;

  logic [PIPE-1:0] vld_r;
  logic [PIPE:0]   rdy;
  logic            out_valid_r;
  rth_pkg::hsl_t   out_data_r;

  rth_pkg::prep_out_t prep_q;
  rth_pkg::div_op_t   hue_ch [rth_pkg::DIV_STAGES+1];
  rth_pkg::div_op_t   sat_ch [rth_pkg::DIV_STAGES+1];

  logic [15:0] lit_r [rth_pkg::DIV_STAGES];
  logic [22:0] lit_y;
  logic [23:0] lit_prod, lit_rem;
  logic [15:0] lit_fix;
  logic [rth_pkg::QUO_W-1:0] hue_q;
  logic [12:0] hue_wrapped;

  // A stage can take new data when it is empty or its contents move on.
  always_comb begin
    rdy[PIPE] = !out_valid_r || !out_stall;
    for (int k = PIPE - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < PIPE; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
      if (rdy[PIPE]) out_valid_r <= vld_r[PIPE-1];
    end
  end

  rth_prep u_prep (
    .clk      (clk),
    .en       (rdy[PREP_STAGES-1:0]),
    .pix_in   (in_data),
    .prep_out (prep_q)
  );

  assign hue_ch[0] = prep_q.hue;
  assign sat_ch[0] = prep_q.sat;

  for (genvar s = 0; s < rth_pkg::DIV_STAGES; s++) begin : g_div
    rth_div_step u_hue_step (
      .clk    (clk),
      .en     (rdy[PREP_STAGES+s]),
      .op_in  (hue_ch[s]),
      .op_out (hue_ch[s+1])
    );
    rth_div_step u_sat_step (
      .clk    (clk),
      .en     (rdy[PREP_STAGES+s]),
      .op_in  (sat_ch[s]),
      .op_out (sat_ch[s+1])
    );
  end

  // The lightness estimate may be one short of the true quotient; a single
  // remainder check finishes it while the divider runs its first stage.
  always_comb begin
    lit_y    = {prep_q.sum, 14'b0} + 23'd127;
    lit_prod = {prep_q.lit_est, 8'b0} - 24'(prep_q.lit_est);
    lit_rem  = 24'(lit_y) - lit_prod;
    lit_fix  = prep_q.lit_est + 16'(lit_rem >= 24'd255);
  end

  always_ff @(posedge clk) begin
    if (rdy[PREP_STAGES]) lit_r[0] <= lit_fix;
    for (int k = 1; k < rth_pkg::DIV_STAGES; k++) begin
      if (rdy[PREP_STAGES+k]) lit_r[k] <= lit_r[k-1];
    end
  end

  // A hue that rounds up to a full turn wraps to zero.
  always_comb begin
    hue_q       = hue_ch[rth_pkg::DIV_STAGES].sh;
    hue_wrapped = (hue_q == rth_pkg::QUO_W'(rth_pkg::HUE_FULL)) ? 13'd0 : hue_q[12:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[PIPE]) begin
      out_data_r.hue_out        <= hue_wrapped;
      out_data_r.saturation_out <= sat_ch[rth_pkg::DIV_STAGES].sh;
      out_data_r.lightness_out  <= lit_r[rth_pkg::DIV_STAGES-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Results stay within their documented ranges.
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.hue_out < rth_pkg::HUE_FULL))
    else $error("hue outside 0..5759");

  a_q15_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r.saturation_out <= rth_pkg::Q15_ONE) &&
                     (out_data_r.lightness_out <= rth_pkg::Q15_ONE)))
    else $error("saturation or lightness above one");

  // With the receiver taking results, the pipeline never pushes back.
  a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // An accepted pixel occupies the first stage on the next cycle.
  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted pixel not captured");

  // A pixel leaving the last stage lands in the output register.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[PIPE-1] && rdy[PIPE]) |=> out_valid_r)
    else $error("result lost at the output register");

endmodule

// ----- dv/hsl_result_checker.sv -----
`timescale 1ns / 100ps
// Checker that predicts each HSL result from the accepted pixels and compares it.
module hsl_result_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_stall,
  input  rth_pkg::pixel_t in_data,
  input  logic            out_valid,
  input  logic            out_stall,
  input  rth_pkg::hsl_t   out_data,
  output int              mismatches,
  output int              results_due
);

  localparam int unsigned REPORT_LIMIT = 10;
  localparam longint unsigned CHAN_FULL = 255;
  localparam longint unsigned SUM_FULL  = 510;

  rth_pkg::hsl_t hsl_due[$];

  // Exact integer HSL of one pixel, rounded to nearest with ties upward.
  function automatic rth_pkg::hsl_t hsl_of(rth_pkg::pixel_t px);
    longint unsigned r      = 64'(px.red_in);
    longint unsigned g      = 64'(px.green_in);
    longint unsigned b      = 64'(px.blue_in);
    longint unsigned sector = 64'(rth_pkg::HUE_SECTOR);
    longint unsigned full   = 64'(rth_pkg::HUE_FULL);
    longint unsigned one    = 64'(rth_pkg::Q15_ONE);
    longint unsigned top, bot, span, total, angle, den;
    rth_pkg::hsl_t res;
    top = r;
    if (g > top) top = g;
    if (b > top) top = b;
    bot = r;
    if (g < bot) bot = g;
    if (b < bot) bot = b;
    span  = top - bot;
    total = top + bot;
    res   = '0;
    if (span != 0) begin
      // Red wins ties, then green; each sector is offset by a third of the circle.
      if (top == r) begin
        angle = (g >= b) ? sector * (g - b) : full * span - sector * (b - g);
      end else if (top == g) begin
        angle = (b >= r) ? 2 * sector * span + sector * (b - r)
                         : 2 * sector * span - sector * (r - b);
      end else begin
        angle = (r >= g) ? 4 * sector * span + sector * (r - g)
                         : 4 * sector * span - sector * (g - r);
      end
      res.hue_out = 13'(((2 * angle + span) / (2 * span)) % full);
      den = (total >= CHAN_FULL) ? SUM_FULL - total : total;
      if (den != 0) res.saturation_out = 16'((2 * span * one + den) / (2 * den));
    end
    res.lightness_out = 16'((2 * total * one + SUM_FULL) / (2 * SUM_FULL));
    return res;
  endfunction

  always @(posedge clk) begin
    rth_pkg::hsl_t want;
    if (!rst_n) begin
      hsl_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (hsl_due.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t: result transferred with no pixel outstanding: h=%0d s=%0d l=%0d",
                     $realtime, out_data.hue_out, out_data.saturation_out,
                     out_data.lightness_out);
          mismatches <= mismatches + 1;
        end else begin
          want = hsl_due.pop_front();
          if (out_data.hue_out !== want.hue_out ||
              out_data.saturation_out !== want.saturation_out ||
              out_data.lightness_out !== want.lightness_out) begin
            if (mismatches < REPORT_LIMIT)
              $display("%0t: hsl mismatch: expected h=%0d s=%0d l=%0d, got h=%0d s=%0d l=%0d",
                       $realtime, want.hue_out, want.saturation_out, want.lightness_out,
                       out_data.hue_out, out_data.saturation_out, out_data.lightness_out);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_valid && !in_stall) hsl_due.push_back(hsl_of(in_data));
    end
    results_due <= hsl_due.size();
  end

endmodule

// ----- dv/tb_rgb_to_hsl.sv -----
`timescale 1ns / 100ps
// Testbench top for the RGB to HSL converter: stimulus, back-pressure and verdict.
module tb_rgb_to_hsl;

  // Pixels in the random part of the run.
  localparam int RANDOM_PIXELS = 400;
  // Cycles the receiver refuses results when the pipeline is to be filled.
  localparam int LONG_HOLD = 150;
  // Cycles without any transfer on either channel before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 1000;
  // Cycles allowed after the last result, a little more than the pipeline latency.
  localparam int DRAIN_CYCLES = 12;

  // Directed pixels as {red, green, blue}: black and white, the primaries and
  // secondaries, a mid grey, ties for the maximum, a red maximum just short of
  // the hue wrap, saturation divisors of one and of full scale, and
  // alternating bit patterns.
  localparam int N_CORNERS = 21;
  localparam logic [23:0] CORNERS [N_CORNERS] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
    24'h00FFFF, 24'hFF00FF, 24'h808080, 24'hC832C8, 24'h0AC8C8, 24'hFF0001,
    24'h010000, 24'hFFFEFE, 24'h807F7F, 24'h7F8080, 24'hAA55AA, 24'h55AA55,
    24'hFF8000, 24'h3C00FF, 24'h000001
  };

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_stall;
  rth_pkg::pixel_t in_data   = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  rth_pkg::hsl_t   out_data;

  int mismatches;
  int results_due;
  // Raised by the stimulus each time it wants the receiver to hold off for a
  // long stretch; the receiver keeps its own count of holds already served.
  int long_holds_wanted = 0;
  int idle_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  rgb_to_hsl u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  hsl_result_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  // Watchdog: a correct block always moves something within the longest
  // stall or gap this bench produces, so a long silence means it has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Idle cycles before the next pixel: mostly none or short, now and then long.
  function automatic int pixel_gap(bit steady);
    int pick;
    pick = $urandom_range(0, 99);
    if (steady || pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 2);
    if (pick < 97) return $urandom_range(3, 10);
    return $urandom_range(20, 60);
  endfunction

  // A random pixel, biased towards grey, tied maxima and the ends of the range.
  function automatic rth_pkg::pixel_t random_pixel();
    rth_pkg::pixel_t p;
    logic [7:0] hi, lo;
    case ($urandom_range(0, 9))
      0: begin
        hi = 8'($urandom_range(0, 255));
        p  = {hi, hi, hi};
      end
      1, 2: begin
        hi = 8'($urandom_range(0, 255));
        lo = 8'($urandom_range(0, hi));
        case ($urandom_range(0, 2))
          0:       p = {hi, hi, lo};
          1:       p = {hi, lo, hi};
          default: p = {lo, hi, hi};
        endcase
      end
      3: begin
        p.red_in   = $urandom_range(0, 1) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(254, 255));
        p.green_in = $urandom_range(0, 1) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(254, 255));
        p.blue_in  = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(254, 255));
      end
      default: p = rth_pkg::pixel_t'(24'($urandom));
    endcase
    return p;
  endfunction

  // Offers one pixel at the falling edge and holds it until a transfer.
  // Called and returns at a falling edge; valid stays high for a following
  // pixel with no gap, so it is never lowered and raised in one time step.
  task automatic send_pixel(rth_pkg::pixel_t p, bit steady);
    int gap;
    gap = pixel_gap(steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Receiver: random stalls of mixed length, stretches with no stall at all,
  // and a long hold whenever the stimulus asks for one.
  initial begin : result_sink
    int holds_served;
    int pick;
    int run;
    holds_served = 0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (long_holds_wanted > holds_served) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          out_stall <= 1'b0;
          run = $urandom_range(1, 8);
        end else if (pick < 60) begin
          out_stall <= 1'b0;
          run = $urandom_range(20, 60);
        end else if (pick < 90) begin
          out_stall <= 1'b1;
          run = $urandom_range(1, 3);
        end else if (pick < 97) begin
          out_stall <= 1'b1;
          run = $urandom_range(4, 12);
        end else begin
          out_stall <= 1'b1;
          run = $urandom_range(20, 60);
        end
        repeat (run) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    bit steady;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int k = 0; k < N_CORNERS; k++) send_pixel(rth_pkg::pixel_t'(CORNERS[k]), 1'b0);

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      // A long receiver hold while pixels keep coming back to back fills the
      // pipeline and must push the stall back to the input.
      if (i == 100 || i == 300) long_holds_wanted++;
      // Halfway through, the sender goes quiet until every result is back.
      if (i == 200) begin
        in_valid <= 1'b0;
        wait (results_due == 0);
        @(negedge clk);
      end
      steady = (i % 100) < 20 || (i >= 100 && i < 140) || (i >= 300 && i < 340);
      send_pixel(random_pixel(), steady);
    end
    in_valid <= 1'b0;

    wait (results_due == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
